// File: hw/rtl/lmss_pkg.sv
package lmss_pkg;

    // Field widths
    localparam int ANGLE_W    = 15;
    localparam int TICK_W     = 16;
    localparam int FREQ_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POS_LEAD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_LEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_TICKS    = 3'd5;

    // Register reset values
    localparam int RST_POS_LEAD = 8000;
    localparam int RST_NEG_LEAD = 0;
    localparam logic [ANGLE_W-1:0] RST_POS_END      = 15'd30037;
    localparam logic [ANGLE_W-1:0] RST_NEG_END      = 15'd2731;
    localparam logic [TICK_W-1:0]  RST_SEARCH_TICKS = 16'd40000;
    localparam logic [TICK_W-1:0]  RST_RUN_TICKS    = 16'd8000;

    // Frequency commands
    localparam logic signed [FREQ_W-1:0] FREQ_SEARCH_POS = 8'sd64;
    localparam logic signed [FREQ_W-1:0] FREQ_SEARCH_NEG = -8'sd64;
    localparam logic signed [FREQ_W-1:0] FREQ_HALT       = 8'sd0;

    typedef enum logic [1:0] {
        MODE_SPOS = 2'd0,
        MODE_SNEG = 2'd1,
        MODE_POS  = 2'd2,
        MODE_NEG  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pos_lead;
        logic [ANGLE_W-1:0] neg_lead;
        logic [ANGLE_W-1:0] pos_end;
        logic [ANGLE_W-1:0] neg_end;
        logic [TICK_W-1:0]  search_ticks;
        logic [TICK_W-1:0]  run_ticks;
    } cfg_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic                      debug_level;
        logic                      stop_request;
        logic                      angle_cmd_valid;
        logic [ANGLE_W-1:0]        angle_cmd;
        logic                      freq_changed;
        logic signed [FREQ_W-1:0]  freq_cmd;
        mode_t                     mode;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

// File: hw/rtl/linear_motor_stroke_sequencer_top.sv
// Linear motor stroke sequencer.
// Slave stream (s_tvalid/s_tready/s_tdata) takes one angle sample word per
// control tick; master stream (m_tvalid/m_tready/m_tdata) returns exactly one
// result word per sample, in order: mode, frequency command, angle command
// and stop request.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// six setup registers; cfg_ready is always high. Write only while no sample
// is in flight. Out-of-range angle writes and unknown indexes are dropped.
// Pipeline: a sample accepted from the slave stream is held in the input
// register; its result word is then loaded into the result register and
// shown on m_tdata (input register, then result register).
// Throughput: one sample per cycle unless m_tready stalls; all work for a sample
// is a single pass of compare/add logic between the input register and the result register.
// Reset (rst_n low, asynchronous) loads register defaults, search-positive
// mode with +64 frequency and a 40000-tick search budget.
// When the receiver stalls the result word holds, the input register still
// takes one more sample, then s_tready drops until the result is taken.
module linear_motor_stroke_sequencer_top #(
    parameter int ANGLE_FULL_SCALE = 32768
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: angle_sample[14:0], zero bit 15
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,
    // m_tdata: mode[1:0], freq_cmd[9:2], freq_changed[10], angle_cmd[25:11],
    //          angle_cmd_valid[26], stop_request[27], debug_level[28], zeros
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lmss_pkg::*;

    cfg_t               cfg;
    res_t               res;
    logic               in_valid_reg;
    logic [ANGLE_W-1:0] in_angle_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;
    logic               out_free, step;

    assign cfg_ready = 1'b1;

    lmss_cfg #(
        .ANGLE_FULL_SCALE (ANGLE_FULL_SCALE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage handshake
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_angle_reg <= s_tdata[ANGLE_W-1:0];
    end

    lmss_core #(
        .ANGLE_FULL_SCALE (ANGLE_FULL_SCALE)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .angle (in_angle_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(32 - RES_W)'(0), out_res_reg};

    // Search modes drive +/-64, run modes drive zero frequency
    a_freq_by_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (out_res_reg.mode == MODE_SPOS && out_res_reg.freq_cmd == FREQ_SEARCH_POS) ||
            (out_res_reg.mode == MODE_SNEG && out_res_reg.freq_cmd == FREQ_SEARCH_NEG) ||
            (out_res_reg.mode == MODE_POS  && out_res_reg.freq_cmd == FREQ_HALT) ||
            (out_res_reg.mode == MODE_NEG  && out_res_reg.freq_cmd == FREQ_HALT))
        else $error("frequency command does not match mode");

    // Angle command reads zero when not issued
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_res_reg.angle_cmd_valid) |-> (out_res_reg.angle_cmd == '0))
        else $error("angle command set without valid");

    // Stop only comes from a run stroke
    a_stop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.stop_request) |->
            (out_res_reg.angle_cmd_valid &&
             (out_res_reg.mode == MODE_POS || out_res_reg.mode == MODE_NEG)))
        else $error("stop request outside run modes");

    // Sequencer state moves only when a word leaves the input register
    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !s_tvalid) |=> !in_valid_reg)
        else $error("input register not released after step");

endmodule

// File: hw/rtl/lmss_cfg.sv
module lmss_cfg #(
    parameter int ANGLE_FULL_SCALE = 32768
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lmss_pkg::cfg_t                    cfg
);
    import lmss_pkg::*;

    // Leads are kept reduced below full scale
    localparam logic [ANGLE_W-1:0] POS_LEAD_RST = ANGLE_W'(RST_POS_LEAD % ANGLE_FULL_SCALE);
    localparam logic [ANGLE_W-1:0] NEG_LEAD_RST = ANGLE_W'(RST_NEG_LEAD % ANGLE_FULL_SCALE);

    cfg_t cfg_reg;
    logic angle_ok;

    // Angle registers take only values below full scale
    assign angle_ok = ({2'b00, cfg_data[ANGLE_W-1:0]} < 17'(ANGLE_FULL_SCALE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_lead     <= POS_LEAD_RST;
            cfg_reg.neg_lead     <= NEG_LEAD_RST;
            cfg_reg.pos_end      <= RST_POS_END;
            cfg_reg.neg_end      <= RST_NEG_END;
            cfg_reg.search_ticks <= RST_SEARCH_TICKS;
            cfg_reg.run_ticks    <= RST_RUN_TICKS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POS_LEAD:     if (angle_ok) cfg_reg.pos_lead <= cfg_data[ANGLE_W-1:0];
                REG_NEG_LEAD:     if (angle_ok) cfg_reg.neg_lead <= cfg_data[ANGLE_W-1:0];
                REG_POS_END:      if (angle_ok) cfg_reg.pos_end  <= cfg_data[ANGLE_W-1:0];
                REG_NEG_END:      if (angle_ok) cfg_reg.neg_end  <= cfg_data[ANGLE_W-1:0];
                REG_SEARCH_TICKS: cfg_reg.search_ticks <= cfg_data;
                REG_RUN_TICKS:    cfg_reg.run_ticks    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/lmss_core.sv
module lmss_core #(
    parameter int ANGLE_FULL_SCALE = 32768
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [lmss_pkg::ANGLE_W-1:0]   angle,
    input  lmss_pkg::cfg_t                 cfg,
    output lmss_pkg::res_t                 res
);
    import lmss_pkg::*;

    // Crossing thresholds: 30, 330 and 180 degrees
    localparam logic [16:0] A30  = 17'((ANGLE_FULL_SCALE + 6) / 12);
    localparam logic [16:0] A330 = 17'(ANGLE_FULL_SCALE - (ANGLE_FULL_SCALE + 6) / 12);
    localparam logic [16:0] A180 = 17'(ANGLE_FULL_SCALE / 2);
    // Conditional subtract steps to reduce a 16-bit value below full scale
    localparam int QSTEPS = $clog2(65536 / ANGLE_FULL_SCALE);

    function automatic logic [15:0] mod_fs(input logic [15:0] x_in);
        logic [16:0] x;
        logic [31:0] part;
        x = {1'b0, x_in};
        part = '0;
        for (int k = QSTEPS - 1; k >= 0; k--)
        begin
            part = 32'(ANGLE_FULL_SCALE) << k;
            if ({15'b0, x} >= part)
                x = x - part[16:0];
        end
        return x[15:0];
    endfunction

    mode_t                     mode_reg, mode_next;
    logic [ANGLE_W-1:0]        prev_reg;
    logic [TICK_W-1:0]         cnt_reg, cnt_next;
    logic                      exp_reg, exp_next;
    logic signed [FREQ_W-1:0]  freq_reg, freq_next;
    logic                      dbg_reg, dbg_next;

    logic [16:0]        ang17, last17;
    logic               wrap, mid, reload;
    logic [15:0]        pos_sum, pos_mod, ang_mod;
    logic [17:0]        neg_diff;
    logic [ANGLE_W-1:0] cmd_pos, cmd_neg, cmd;
    logic               cmd_valid, fchg, stop;
    logic [TICK_W-1:0]  run_cnt;
    logic               run_exp;

    assign ang17  = {2'b00, angle};
    assign last17 = {2'b00, prev_reg};

    // Detect wrap and mid-stroke crossings
    assign wrap = (ang17 < A30 && last17 > A330) || (ang17 > A330 && last17 < A30);
    assign mid  = !wrap && ((ang17 >= A180 && last17 < A180) ||
                            (ang17 <= A180 && last17 > A180));

    // Angle commands, modulo full scale
    assign pos_sum = {1'b0, angle} + {1'b0, cfg.pos_lead};
    assign pos_mod = mod_fs(pos_sum);
    assign cmd_pos = pos_mod[ANGLE_W-1:0];
    assign ang_mod = mod_fs({1'b0, angle});
    always_comb
    begin
        if (ang_mod >= {1'b0, cfg.neg_lead})
            neg_diff = {2'b00, ang_mod} - {3'b000, cfg.neg_lead};
        else
            neg_diff = {2'b00, ang_mod} + 18'(ANGLE_FULL_SCALE) - {3'b000, cfg.neg_lead};
    end
    assign cmd_neg = neg_diff[ANGLE_W-1:0];

    // Next state for one sample
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        freq_next = freq_reg;
        dbg_next  = dbg_reg;
        fchg      = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        stop      = 1'b0;
        reload    = 1'b0;
        run_cnt   = cnt_reg;
        run_exp   = exp_reg;

        unique case (mode_reg)
            MODE_SPOS, MODE_SNEG:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next = cfg.search_ticks;
                    exp_next = 1'b0;
                    fchg     = 1'b1;
                    if (mode_reg == MODE_SPOS)
                    begin
                        freq_next = FREQ_SEARCH_NEG;
                        mode_next = MODE_SNEG;
                    end
                    else
                    begin
                        freq_next = FREQ_SEARCH_POS;
                        mode_next = MODE_SPOS;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                // Mid-stroke wins over a reversal
                if (mid)
                begin
                    freq_next = FREQ_HALT;
                    fchg      = 1'b1;
                    cnt_next  = cfg.run_ticks;
                    exp_next  = 1'b0;
                    mode_next = MODE_POS;
                end
            end
            MODE_POS:
            begin
                cmd       = cmd_pos;
                cmd_valid = 1'b1;
                reload    = !wrap && angle >= cfg.pos_end && prev_reg < cfg.pos_end;
                if (reload)
                    mode_next = MODE_NEG;
                dbg_next  = 1'b1;
            end
            MODE_NEG:
            begin
                cmd       = cmd_neg;
                cmd_valid = 1'b1;
                reload    = !wrap && angle <= cfg.neg_end && prev_reg > cfg.neg_end;
                if (reload)
                    mode_next = MODE_POS;
                dbg_next  = 1'b0;
            end
        endcase

        // Stroke budget: reload, then count down or raise stop once
        if (mode_reg == MODE_POS || mode_reg == MODE_NEG)
        begin
            run_cnt = reload ? cfg.run_ticks : cnt_reg;
            run_exp = reload ? 1'b0 : exp_reg;
            if (run_exp)
            begin
                cnt_next = run_cnt;
                exp_next = 1'b1;
            end
            else if (run_cnt == '0)
            begin
                cnt_next = run_cnt;
                exp_next = 1'b1;
                stop     = 1'b1;
            end
            else
            begin
                cnt_next = run_cnt - 1'b1;
                exp_next = 1'b0;
            end
        end
    end

    // Hold sequencer state, advance on each sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SPOS;
            prev_reg <= '0;
            cnt_reg  <= RST_SEARCH_TICKS;
            exp_reg  <= 1'b0;
            freq_reg <= FREQ_SEARCH_POS;
            dbg_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            prev_reg <= angle;
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
            freq_reg <= freq_next;
            dbg_reg  <= dbg_next;
        end
    end

    assign res.mode            = mode_next;
    assign res.freq_cmd        = freq_next;
    assign res.freq_changed    = fchg;
    assign res.angle_cmd       = cmd;
    assign res.angle_cmd_valid = cmd_valid;
    assign res.stop_request    = stop;
    assign res.debug_level     = dbg_next;

endmodule
